// ===== rtl/aist_pkg.sv =====
// Shared types, codes and the opcode length table for the instruction traffic tally.
// No dependencies; imported by every module of the block.
package aist_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned SUM_W = 32;
  localparam int unsigned BANK_W = 6;
  localparam int unsigned AMT_W = 23;
  localparam int unsigned OUT_DATA_W = 104;

  localparam logic [3:0] OP_LOAD = 4'b0000;
  localparam logic [3:0] OP_SAVE = 4'b0100;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_SAVE = 2'd2;

  localparam logic [1:0] DEST_NONE = 2'd0;
  localparam logic [1:0] DEST_IMAGE = 2'd1;
  localparam logic [1:0] DEST_PARAM = 2'd2;
  localparam logic [1:0] DEST_SAVE = 2'd3;

  localparam logic [BANK_W-1:0] PARAM_BANK_START_RST = 6'd16;

  typedef struct packed {
    logic [1:0]       dest;
    logic [AMT_W-1:0] amount;
    logic             last;
    logic             err;
  } entry_t;

  // Instruction length in words; zero marks an unlisted opcode.
  function automatic logic [2:0] instr_len(input logic [3:0] op);
    logic [2:0] len;
    len = 3'd0;
    unique case (op)
      OP_LOAD: len = 3'd4;
      OP_SAVE: len = 3'd4;
      4'b0110: len = 3'd2;
      4'b0111: len = 3'd1;
      4'b1000: len = 3'd5;
      4'b1001: len = 3'd4;
      4'b1010: len = 3'd5;
      4'b1011: len = 3'd3;
      4'b1100: len = 3'd5;
      4'b1101: len = 3'd2;
      4'b1110: len = 3'd3;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/accel_instr_stream_traffic_tally_top.sv =====
// Throughput: one instruction word per cycle while the result side keeps up.
// A last word is written into the queue, then popped into the result register that drives out_tvalid.
// The queue of DEPTH entries lets the front keep taking words while a result waits.
// Reset is synchronous and active low: totals, error flag, parse state and queue clear,
// and param_bank_start returns to 16.
module accel_instr_stream_traffic_tally_top
  import aist_pkg::*;
#(
  parameter int unsigned DEPTH = 4
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [BANK_W-1:0]     cfg_data,   // param_bank_start
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [WORD_W-1:0]     in_tdata,   // code_word
  input  logic                  in_tlast,   // last_word
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // load_image_total, load_param_total,
                                            // save_total, bad_opcode_seen, zero pad
);

  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   q_not_full;
  logic   q_not_empty;

  aist_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_ready    (q_not_full),
    .push       (push),
    .push_entry (push_entry)
  );

  aist_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (q_not_full),
    .not_empty  (q_not_empty),
    .pop        (pop),
    .head       (head)
  );

  aist_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

// ===== rtl/aist_front.sv =====
// Front end: accepts instruction words, tracks instruction boundaries and builds
// accumulate entries for the queue. Depends on aist_pkg.
module aist_front
  import aist_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BANK_W-1:0] cfg_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [WORD_W-1:0] in_tdata,
  input  logic              in_tlast,
  input  logic              q_ready,
  output logic              push,
  output entry_t            push_entry
);

  logic [2:0]        wi_r, wi_nxt;
  logic [2:0]        words_r, words_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic              bank_r, bank_nxt;
  logic              err_r, err_nxt;
  logic [BANK_W-1:0] pbs_r;
  logic [3:0]        op;
  logic [2:0]        len_lut;
  logic [2:0]        wi_inc;
  logic [1:0]        dest;
  logic [AMT_W-1:0]  chan_x;
  logic [AMT_W-1:0]  len_x;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign in_tready = q_ready;
  assign accept = in_tvalid && in_tready;

  assign op = in_tdata[31:28];
  assign len_lut = instr_len(op);
  assign wi_inc = wi_r + 3'd1;

  assign chan_x = AMT_W'(in_tdata[11:0]) + AMT_W'(1);
  assign len_x = AMT_W'(in_tdata[23:14]) + AMT_W'(1);

  always_comb begin
    words_nxt = words_r;
    kind_nxt = kind_r;
    bank_nxt = bank_r;
    err_nxt = err_r;
    dest = DEST_NONE;
    if (wi_r == 3'd0) begin
      words_nxt = (len_lut == 3'd0) ? 3'd1 : len_lut;
      err_nxt = err_r | (len_lut == 3'd0);
      if (op == OP_LOAD) begin
        kind_nxt = KIND_LOAD;
      end else if (op == OP_SAVE) begin
        kind_nxt = KIND_SAVE;
      end else begin
        kind_nxt = KIND_OTHER;
      end
      bank_nxt = (in_tdata[17:12] >= pbs_r);
    end else if (wi_r == 3'd2 && kind_r != KIND_OTHER) begin
      if (kind_r == KIND_SAVE) begin
        dest = DEST_SAVE;
      end else if (bank_r) begin
        dest = DEST_PARAM;
      end else begin
        dest = DEST_IMAGE;
      end
    end
    wi_nxt = (wi_inc >= words_nxt) ? 3'd0 : wi_inc;
    if (in_tlast) begin
      wi_nxt = 3'd0;
      words_nxt = 3'd0;
      kind_nxt = KIND_OTHER;
      bank_nxt = 1'b0;
    end
  end

  assign push = accept && (dest != DEST_NONE || in_tlast);
  assign push_entry.dest = dest;
  assign push_entry.amount = chan_x * len_x;
  assign push_entry.last = in_tlast;
  assign push_entry.err = err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r <= 3'd0;
      words_r <= 3'd0;
      kind_r <= KIND_OTHER;
      bank_r <= 1'b0;
      err_r <= 1'b0;
      pbs_r <= PARAM_BANK_START_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pbs_r <= cfg_data;
      end
      if (accept) begin
        wi_r <= wi_nxt;
        words_r <= words_nxt;
        kind_r <= kind_nxt;
        bank_r <= bank_nxt;
        err_r <= err_nxt;
      end
    end
  end

endmodule

// ===== rtl/aist_queue.sv =====
// Short queue of accumulate entries between the front end and the back end.
// Depends on aist_pkg.
module aist_queue
  import aist_pkg::*;
#(
  parameter int unsigned DEPTH = 4
)
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   not_full,
  output logic   not_empty,
  input  logic   pop,
  output entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push;
  logic               do_pop;

  assign not_full = (cnt_r != CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push = push && not_full;
  assign do_pop = pop && not_empty;
  assign head = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/aist_back.sv =====
// Back end: drains accumulate entries into the three running totals and drives
// the result register. Depends on aist_pkg.
module aist_back
  import aist_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  entry_t                head,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [SUM_W-1:0] img_r, par_r, sav_r;
  logic [SUM_W-1:0] img_add, par_add, sav_add;
  logic [SUM_W-1:0] amt_x;
  logic             out_valid_r;
  logic [SUM_W-1:0] out_img_r, out_par_r, out_sav_r;
  logic             out_err_r;

  assign amt_x = SUM_W'(head.amount);
  assign img_add = img_r + ((head.dest == DEST_IMAGE) ? amt_x : '0);
  assign par_add = par_r + ((head.dest == DEST_PARAM) ? amt_x : '0);
  assign sav_add = sav_r + ((head.dest == DEST_SAVE) ? amt_x : '0);

  assign pop = q_not_empty && (!head.last || !out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata = {7'b0, out_err_r, out_sav_r, out_par_r, out_img_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_r <= '0;
      par_r <= '0;
      sav_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (head.last) begin
          img_r <= '0;
          par_r <= '0;
          sav_r <= '0;
        end else begin
          img_r <= img_add;
          par_r <= par_add;
          sav_r <= sav_add;
        end
      end
      if (pop && head.last) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_img_r <= img_add;
      out_par_r <= par_add;
      out_sav_r <= sav_add;
      out_err_r <= head.err;
    end
  end

endmodule

// ===== rtl/aist_checker.sv =====
// Port-level checks for the instruction traffic tally, bound to the top level.
// Depends on aist_pkg and accel_instr_stream_traffic_tally_top.
module aist_checker
  import aist_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [7:0] pending_r;
  logic       seen_bad_r;
  logic       in_last_acc;
  logic       out_acc;

  assign in_last_acc = in_tvalid && in_tready && in_tlast;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 8'd0;
      seen_bad_r <= 1'b0;
    end else begin
      pending_r <= pending_r + {7'd0, in_last_acc} - {7'd0, out_acc};
      if (out_acc && out_tdata[96]) begin
        seen_bad_r <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result transaction changed while stalled.");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result valid after reset.");

  a_result_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pending_r != 8'd0)
    else $error("Result transaction without a preceding last word.");

  a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && seen_bad_r |-> out_tdata[96])
    else $error("Bad opcode flag cleared before reset.");

endmodule

bind accel_instr_stream_traffic_tally_top aist_checker u_aist_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/tb_accel_instr_stream_traffic_tally_top.sv =====
// Self-checking testbench for the instruction-stream traffic tally.
// Streams programs word by word, predicts the three totals and the error flag, and checks results.
// Depends on aist_pkg and accel_instr_stream_traffic_tally_top from the rtl folder.
module tb_accel_instr_stream_traffic_tally_top;
  import aist_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_GAP = 15;
  localparam int RANDOM_WORDS = 500;
  localparam int PHASE_WORDS = 100;
  localparam int NO_LAST = 99;
  localparam logic [5:0] BANK_MAX = 6'd63;
  localparam logic [11:0] CHAN_MAX = 12'hFFF;
  localparam logic [9:0] LEN_MAX = 10'h3FF;

  localparam logic [2:0] WORDS_PER_OP [16] = '{
    3'd4, 3'd0, 3'd0, 3'd0, 3'd4, 3'd0, 3'd2, 3'd1,
    3'd5, 3'd4, 3'd5, 3'd3, 3'd5, 3'd2, 3'd3, 3'd0
  };
  localparam logic [3:0] VALID_OPS [11] = '{
    4'b0000, 4'b0100, 4'b0110, 4'b0111, 4'b1000, 4'b1001,
    4'b1010, 4'b1011, 4'b1100, 4'b1101, 4'b1110
  };
  localparam logic [3:0] UNKNOWN_OPS [5] = '{4'b0001, 4'b0010, 4'b0011, 4'b0101, 4'b1111};
  localparam logic [3:0] OP_ONE_WORD = 4'b0111;

  typedef struct packed {
    logic [SUM_W-1:0] image;
    logic [SUM_W-1:0] param;
    logic [SUM_W-1:0] save;
    logic             bad;
  } tally_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [BANK_W-1:0]     cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [WORD_W-1:0]     in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Predicted state of the block.
  logic [BANK_W-1:0] bank_start_m = PARAM_BANK_START_RST;
  logic [2:0]        pos_m = '0;
  logic [2:0]        words_m = '0;
  logic [1:0]        kind_m = KIND_OTHER;
  logic              param_m = 1'b0;
  logic [SUM_W-1:0]  image_m = '0;
  logic [SUM_W-1:0]  param_sum_m = '0;
  logic [SUM_W-1:0]  save_m = '0;
  logic              err_m = 1'b0;

  tally_t expected_tallies[$];
  int     mismatch_count = 0;
  int     words_sent = 0;
  bit     tx_no_stall = 1'b0;
  bit     rx_no_stall = 1'b0;
  int     hold_request = 0;
  int     rx_hold = 0;
  int     rx_wait = 0;

  accel_instr_stream_traffic_tally_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("tb_accel_instr_stream_traffic_tally_top NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    mismatch_count++;
  endtask

  task automatic tally_word(input logic [31:0] w, input logic l);
    logic [3:0]       op;
    logic [2:0]       n;
    logic [AMT_W-1:0] amt;
    tally_t           t;
    if (pos_m == 3'd0) begin
      op = w[31:28];
      n = WORDS_PER_OP[op];
      if (n == 3'd0) begin
        err_m = 1'b1;
        n = 3'd1;
      end
      words_m = n;
      kind_m = (op == OP_LOAD) ? KIND_LOAD : (op == OP_SAVE) ? KIND_SAVE : KIND_OTHER;
      param_m = (w[17:12] >= bank_start_m);
    end else if (pos_m == 3'd2 && kind_m != KIND_OTHER) begin
      amt = (AMT_W'(w[11:0]) + 1'b1) * (AMT_W'(w[23:14]) + 1'b1);
      if (kind_m == KIND_SAVE) save_m = save_m + SUM_W'(amt);
      else if (param_m) param_sum_m = param_sum_m + SUM_W'(amt);
      else image_m = image_m + SUM_W'(amt);
    end
    pos_m = pos_m + 3'd1;
    if (pos_m >= words_m) pos_m = 3'd0;
    if (l) begin
      t.image = image_m;
      t.param = param_sum_m;
      t.save = save_m;
      t.bad = err_m;
      expected_tallies.push_back(t);
      image_m = '0;
      param_sum_m = '0;
      save_m = '0;
      pos_m = '0;
      words_m = '0;
      kind_m = KIND_OTHER;
      param_m = 1'b0;
    end
  endtask

  task automatic check_tally(input logic [OUT_DATA_W-1:0] d);
    tally_t t;
    if (expected_tallies.size() == 0) begin
      report_mismatch("result with none expected", d[31:0], '0);
      return;
    end
    t = expected_tallies.pop_front();
    if (d[31:0] !== t.image) report_mismatch("load_image_total", d[31:0], t.image);
    if (d[63:32] !== t.param) report_mismatch("load_param_total", d[63:32], t.param);
    if (d[95:64] !== t.save) report_mismatch("save_total", d[95:64], t.save);
    if (d[96] !== t.bad) report_mismatch("bad_opcode_seen", 32'(d[96]), 32'(t.bad));
    if (d[OUT_DATA_W-1:97] !== '0) report_mismatch("pad bits", 32'(d[OUT_DATA_W-1:97]), '0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_tally(out_tdata);
        rx_wait = rx_no_stall ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold_request != 0) begin
        rx_hold = hold_request;
        hold_request = 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [31:0] w, input logic l);
    int gap;
    gap = tx_no_stall ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    in_tlast <= l;
    do @(posedge clk); while (!in_tready);
    tally_word(w, l);
    words_sent++;
  endtask

  task automatic tx_idle();
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_drained();
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bank_start(input logic [BANK_W-1:0] v);
    tx_idle();
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bank_start_m = v;
  endtask

  // Sends one instruction; the word at index last_at carries tlast and may end it early.
  task automatic send_instr(input logic [3:0] op, input logic [5:0] bank,
                            input logic [11:0] chan, input logic [9:0] len, input int last_at);
    logic [31:0] w;
    int          n;
    n = (WORDS_PER_OP[op] == 3'd0) ? 1 : int'(WORDS_PER_OP[op]);
    for (int i = 0; i < n; i++) begin
      w = $urandom;
      if (i == 0) begin
        w[31:28] = op;
        w[17:12] = bank;
      end else if (i == 2 && (op == OP_LOAD || op == OP_SAVE)) begin
        w[11:0] = chan;
        w[23:14] = len;
      end
      send_word(w, i == last_at);
      if (i == last_at) break;
    end
  endtask

  function automatic int op_words(input logic [3:0] op);
    return (WORDS_PER_OP[op] == 3'd0) ? 1 : int'(WORDS_PER_OP[op]);
  endfunction

  function automatic logic [11:0] pick_chan();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CHAN_MAX;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] pick_len();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return LEN_MAX;
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_op();
    int r;
    r = $urandom_range(0, 19);
    if (r < 7) return OP_LOAD;
    if (r < 12) return OP_SAVE;
    if (r < 19) return VALID_OPS[$urandom_range(0, 10)];
    return UNKNOWN_OPS[$urandom_range(0, 4)];
  endfunction

  task automatic send_random_program(input int n_instr, input bit truncate);
    logic [3:0] op;
    int         last_at;
    for (int k = 0; k < n_instr; k++) begin
      op = pick_op();
      last_at = NO_LAST;
      if (k == n_instr - 1)
        last_at = truncate ? $urandom_range(0, op_words(op) - 1) : op_words(op) - 1;
      send_instr(op, 6'($urandom), pick_chan(), pick_len(), last_at);
    end
  endtask

  task automatic test_default_threshold();
    send_instr(OP_LOAD, PARAM_BANK_START_RST - 1'b1, '0, '0, NO_LAST);
    send_instr(OP_LOAD, PARAM_BANK_START_RST, CHAN_MAX, LEN_MAX, NO_LAST);
    send_instr(OP_SAVE, BANK_MAX, CHAN_MAX, '0, 3);
    send_instr(OP_ONE_WORD, '0, '0, '0, 0);
    tx_idle();
    wait_results_drained();
  endtask

  task automatic test_every_opcode();
    for (int i = 0; i < 11; i++)
      send_instr(VALID_OPS[i], 6'($urandom), pick_chan(), pick_len(),
                 (i == 10) ? op_words(VALID_OPS[i]) - 1 : NO_LAST);
    tx_idle();
    wait_results_drained();
  endtask

  task automatic test_truncated_instruction();
    send_instr(OP_LOAD, '0, CHAN_MAX, LEN_MAX, 1);
    send_instr(OP_SAVE, '0, 12'd5, 10'd7, 2);
    tx_idle();
    wait_results_drained();
  endtask

  task automatic test_threshold_extremes();
    write_bank_start('0);
    send_instr(OP_LOAD, '0, 12'd3, 10'd1, 3);
    write_bank_start(BANK_MAX);
    send_instr(OP_LOAD, BANK_MAX - 1'b1, 12'd2, 10'd2, NO_LAST);
    send_instr(OP_LOAD, BANK_MAX, 12'd9, 10'd4, 3);
    write_bank_start(PARAM_BANK_START_RST);
  endtask

  task automatic test_output_backpressure();
    tx_no_stall = 1'b1;
    hold_request = 200;
    for (int i = 0; i < 24; i++) send_instr(OP_ONE_WORD, '0, '0, '0, 0);
    tx_no_stall = 1'b0;
    tx_idle();
    wait_results_drained();
  endtask

  task automatic test_unknown_opcode();
    for (int i = 0; i < 5; i++) send_instr(UNKNOWN_OPS[i], '0, '0, '0, NO_LAST);
    send_instr(OP_SAVE, '0, 12'd1, 10'd1, 3);
    send_instr(OP_LOAD, '0, 12'd1, 10'd1, 3);
    tx_idle();
    wait_results_drained();
  endtask

  task automatic test_random_programs();
    int start;
    int phase_end;
    logic [BANK_W-1:0] th;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      case ($urandom_range(0, 3))
        0: th = '0;
        1: th = BANK_MAX;
        default: th = 6'($urandom);
      endcase
      write_bank_start(th);
      tx_no_stall = ($urandom_range(0, 3) == 0);
      rx_no_stall = ($urandom_range(0, 3) == 0);
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 6) != 0) begin
          send_random_program($urandom_range(1, 6), $urandom_range(0, 4) == 0);
        end else begin
          repeat ($urandom_range(1, 4)) send_word($urandom, $urandom_range(0, 7) == 0);
        end
      end
    end
    send_instr(OP_ONE_WORD, '0, '0, '0, 0);
    tx_no_stall = 1'b0;
    rx_no_stall = 1'b0;
    tx_idle();
    wait_results_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_threshold();
    test_every_opcode();
    test_truncated_instruction();
    test_threshold_extremes();
    test_output_backpressure();
    test_unknown_opcode();
    test_random_programs();
    if (expected_tallies.size() != 0)
      report_mismatch("results never delivered", expected_tallies.size(), '0);
    if (mismatch_count == 0) begin
      $display("tb_accel_instr_stream_traffic_tally_top OK");
    end else begin
      $display("tb_accel_instr_stream_traffic_tally_top NOT OK");
    end
    $finish;
  end

endmodule
